### rtl/c8ie_pkg.sv
// Package with the shared constants, types and font table of the CHIP-8 execute core.
`default_nettype none
package c8ie_pkg;

	localparam int MEMORY_BYTES  = 4096;
	localparam int PROGRAM_START = 512;
	localparam int GLYPH_HEIGHT  = 5;
	localparam int STACK_DEPTH   = 16;

	localparam int MEM_AW = $clog2(MEMORY_BYTES);
	localparam int STK_AW = $clog2(STACK_DEPTH);
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int FONT_BYTES = 80;

	localparam logic [11:0] PC_START = 12'(PROGRAM_START);

	localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_EXEC = 2'd1,
		OP_READ = 2'd2,
		OP_ROW  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ALU_PASSB,
		ALU_OR,
		ALU_AND,
		ALU_XOR,
		ALU_ADD,
		ALU_SUB,
		ALU_SHR,
		ALU_SHL
	} alu_op_t;

	typedef struct packed {
		logic [7:0] res;
		logic       flag;
		logic       eq;
		logic       ge;
	} alu_res_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_MEMW, ST_MRD, ST_MRD2, ST_FRD, ST_FRD2,
		ST_FETCH, ST_RDX, ST_RDY, ST_RD0, ST_DECODE, ST_FLAG, ST_CLS, ST_RET,
		ST_DRAW_A, ST_DRAW_B, ST_DRAW_F, ST_BCD_H, ST_BCD_T, ST_BCD_W,
		ST_STORE_A, ST_STORE_B, ST_LOAD_A, ST_LOAD_B, ST_DONE
	} state_t;

endpackage
`default_nettype wire

### rtl/c8ie_alu.sv
// Shared 8-bit arithmetic, logic, shift and compare unit of the execute core.
`default_nettype none
module c8ie_alu (
	input  var c8ie_pkg::alu_op_t  alu_op,
	input  wire logic [7:0]        a,
	input  wire logic [7:0]        b,
	output c8ie_pkg::alu_res_t     result
);

	logic [8:0] sum;
	logic [8:0] diff;

	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = {1'b0, a} - {1'b0, b};

	always_comb begin
		result.eq   = (a == b);
		result.ge   = !diff[8];
		result.res  = b;
		result.flag = 1'b0;
		case (alu_op)
			c8ie_pkg::ALU_PASSB: result.res = b;
			c8ie_pkg::ALU_OR:    result.res = a | b;
			c8ie_pkg::ALU_AND:   result.res = a & b;
			c8ie_pkg::ALU_XOR:   result.res = a ^ b;
			c8ie_pkg::ALU_ADD: begin
				result.res  = sum[7:0];
				result.flag = sum[8];
			end
			c8ie_pkg::ALU_SUB: begin
				result.res  = diff[7:0];
				result.flag = !diff[8] && (a != b);
			end
			c8ie_pkg::ALU_SHR: begin
				result.res  = {1'b0, a[7:1]};
				result.flag = a[0];
			end
			c8ie_pkg::ALU_SHL: begin
				result.res  = {a[6:0], 1'b0};
				result.flag = a[7];
			end
			default: result.res = b;
		endcase
	end

endmodule
`default_nettype wire

### rtl/chip8_instruction_execute_core.sv
// Top level of the CHIP-8 execute core: sequencer, register file, stack, memory and display.
`default_nettype none
// A transfer is taken when start is high and busy is low; the core then stays busy until the
// one result is shown for a single cycle with done high. The receiver cannot stall, so the
// result must be captured in that cycle. After reset the core stays busy while a clearing
// pass writes the font into memory and zeroes the display and the V registers. How long each
// operation takes is set by the single registered read port of each store (V registers,
// memory, display) and by the one shared ALU, through which rows and registers pass one
// per step.
module chip8_instruction_execute_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] opcode,
	input  wire logic [11:0] address,
	input  wire logic [7:0]  data,
	input  wire logic [15:0] keys_down,
	input  wire logic [3:0]  key_value,
	input  wire logic        key_present,
	input  wire logic [7:0]  random_byte,
	input  wire logic [4:0]  row_select,
	output logic [11:0]      program_counter,
	output logic [15:0]      index_value,
	output logic [7:0]       flag_value,
	output logic [7:0]       byte_out,
	output logic [63:0]      row_pixels,
	output logic             key_wait,
	output logic             stack_fault
);

	localparam int AW  = c8ie_pkg::MEM_AW;
	localparam int SAW = c8ie_pkg::STK_AW;
	localparam int SPW = c8ie_pkg::SP_W;

	c8ie_pkg::state_t state_q, state_d;

	// Captured transfer.
	logic [15:0] opcode_q;
	logic [11:0] addr_q;
	logic [7:0]  data_q;
	logic [15:0] keys_q;
	logic [3:0]  keyv_q;
	logic        keyp_q;
	logic [7:0]  rnd_q;
	logic [4:0]  rsel_q;

	// Architectural state.
	logic [11:0]    pc_q;
	logic [15:0]    i_q;
	logic [7:0]     vf_q;
	logic [7:0]     delay_q;
	logic [7:0]     sound_q;
	logic [SPW-1:0] sp_q;

	// Working registers.
	logic [AW-1:0] cnt_q;
	logic [7:0]    vx_q, vy_q, v0_q;
	logic          flag_q;
	logic          hit_q;
	logic [1:0]    hund_q;
	logic [3:0]    tens_q;
	logic [7:0]    rem_q;

	// Result registers.
	logic [7:0]  byte_q;
	logic [63:0] row_q;
	logic        wait_q;
	logic        fault_q;

	// Stores with registered read data.
	logic [7:0]  mem_q [c8ie_pkg::MEMORY_BYTES];
	logic [63:0] fr_q  [32];
	logic [7:0]  gp_q  [16];
	logic [11:0] stk_q [c8ie_pkg::STACK_DEPTH];
	logic [7:0]  mem_rd_q;
	logic [63:0] fr_rd_q;
	logic [7:0]  gp_rd_q;
	logic [11:0] stk_rd_q;

	// Store port controls.
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic          fr_we;
	logic [4:0]    fr_addr;
	logic [63:0]   fr_wdata;
	logic          gp_we;
	logic [3:0]    gp_waddr;
	logic [3:0]    gp_raddr;
	logic [7:0]    gp_wdata;
	logic          stk_we;
	logic [SAW-1:0] stk_raddr;

	c8ie_pkg::alu_op_t  alu_op;
	logic [7:0]         alu_a, alu_b;
	c8ie_pkg::alu_res_t alu;

	// Instruction fields.
	logic [3:0]  f_hi, f_x, f_y, f_n;
	logic [7:0]  f_kk;
	logic [11:0] f_nnn;

	assign f_hi  = opcode_q[15:12];
	assign f_x   = opcode_q[11:8];
	assign f_y   = opcode_q[7:4];
	assign f_n   = opcode_q[3:0];
	assign f_kk  = opcode_q[7:0];
	assign f_nnn = opcode_q[11:0];

	// Addresses formed from I wrap at 16 bits and read as zero beyond the memory.
	logic [15:0] idx_addr;
	logic        idx_ok;
	logic        addr_ok;
	assign idx_addr = i_q + 16'(cnt_q[3:0]);
	assign idx_ok   = 17'(idx_addr) < 17'(c8ie_pkg::MEMORY_BYTES);
	assign addr_ok  = 13'(addr_q) < 13'(c8ie_pkg::MEMORY_BYTES);

	logic        key_held;
	logic        arith_flagged;
	logic        arith_valid;
	logic [63:0] sprite_bits;
	logic [127:0] sprite_pair;
	logic [7:0]  sprite_byte;

	assign key_held = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];
	assign arith_flagged = (f_n == 4'h4) || (f_n == 4'h5) || (f_n == 4'h6) ||
		(f_n == 4'h7) || (f_n == 4'hE);
	assign arith_valid = arith_flagged || (f_n == 4'h0) || (f_n == 4'h1) ||
		(f_n == 4'h2) || (f_n == 4'h3);

	// The sprite byte sits at the left of the row and is rotated right by the column.
	assign sprite_byte = idx_ok ? mem_rd_q : 8'd0;
	assign sprite_pair = {sprite_byte, 56'd0, sprite_byte, 56'd0} >> vx_q[5:0];
	assign sprite_bits = sprite_pair[63:0];

	c8ie_alu u_alu (
		.alu_op (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.result (alu)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			c8ie_pkg::ST_INIT:
				if (cnt_q == AW'(c8ie_pkg::MEMORY_BYTES - 1)) state_d = c8ie_pkg::ST_IDLE;
			c8ie_pkg::ST_IDLE:
				if (start) begin
					case (op)
						c8ie_pkg::OP_LOAD: state_d = c8ie_pkg::ST_MEMW;
						c8ie_pkg::OP_EXEC: state_d = c8ie_pkg::ST_FETCH;
						c8ie_pkg::OP_READ: state_d = c8ie_pkg::ST_MRD;
						default:           state_d = c8ie_pkg::ST_FRD;
					endcase
				end
			c8ie_pkg::ST_MEMW:  state_d = c8ie_pkg::ST_DONE;
			c8ie_pkg::ST_MRD:   state_d = c8ie_pkg::ST_MRD2;
			c8ie_pkg::ST_MRD2:  state_d = c8ie_pkg::ST_DONE;
			c8ie_pkg::ST_FRD:   state_d = c8ie_pkg::ST_FRD2;
			c8ie_pkg::ST_FRD2:  state_d = c8ie_pkg::ST_DONE;
			c8ie_pkg::ST_FETCH: state_d = c8ie_pkg::ST_RDX;
			c8ie_pkg::ST_RDX:   state_d = c8ie_pkg::ST_RDY;
			c8ie_pkg::ST_RDY:   state_d = c8ie_pkg::ST_RD0;
			c8ie_pkg::ST_RD0:   state_d = c8ie_pkg::ST_DECODE;
			c8ie_pkg::ST_DECODE: begin
				state_d = c8ie_pkg::ST_DONE;
				case (f_hi)
					4'h0: begin
						if (opcode_q == 16'h00E0) state_d = c8ie_pkg::ST_CLS;
						else if (opcode_q == 16'h00EE && sp_q != '0)
							state_d = c8ie_pkg::ST_RET;
					end
					4'h8: if (arith_flagged) state_d = c8ie_pkg::ST_FLAG;
					4'hD: state_d = (f_n == 4'd0) ? c8ie_pkg::ST_DRAW_F : c8ie_pkg::ST_DRAW_A;
					4'hF: begin
						if (f_kk == 8'h33) state_d = c8ie_pkg::ST_BCD_H;
						else if (f_kk == 8'h55) state_d = c8ie_pkg::ST_STORE_A;
						else if (f_kk == 8'h65) state_d = c8ie_pkg::ST_LOAD_A;
					end
					default: state_d = c8ie_pkg::ST_DONE;
				endcase
			end
			c8ie_pkg::ST_FLAG: state_d = c8ie_pkg::ST_DONE;
			c8ie_pkg::ST_CLS:
				if (cnt_q[4:0] == 5'd31) state_d = c8ie_pkg::ST_DONE;
			c8ie_pkg::ST_RET:    state_d = c8ie_pkg::ST_DONE;
			c8ie_pkg::ST_DRAW_A: state_d = c8ie_pkg::ST_DRAW_B;
			c8ie_pkg::ST_DRAW_B:
				state_d = (cnt_q[3:0] == f_n - 4'd1) ? c8ie_pkg::ST_DRAW_F : c8ie_pkg::ST_DRAW_A;
			c8ie_pkg::ST_DRAW_F: state_d = c8ie_pkg::ST_DONE;
			c8ie_pkg::ST_BCD_H:  state_d = c8ie_pkg::ST_BCD_T;
			c8ie_pkg::ST_BCD_T:
				if (!alu.ge) state_d = c8ie_pkg::ST_BCD_W;
			c8ie_pkg::ST_BCD_W:
				if (cnt_q[1:0] == 2'd2) state_d = c8ie_pkg::ST_DONE;
			c8ie_pkg::ST_STORE_A: state_d = c8ie_pkg::ST_STORE_B;
			c8ie_pkg::ST_STORE_B:
				state_d = (cnt_q[3:0] == f_x) ? c8ie_pkg::ST_DONE : c8ie_pkg::ST_STORE_A;
			c8ie_pkg::ST_LOAD_A: state_d = c8ie_pkg::ST_LOAD_B;
			c8ie_pkg::ST_LOAD_B:
				state_d = (cnt_q[3:0] == f_x) ? c8ie_pkg::ST_DONE : c8ie_pkg::ST_LOAD_A;
			c8ie_pkg::ST_DONE: state_d = c8ie_pkg::ST_IDLE;
			default: state_d = c8ie_pkg::ST_IDLE;
		endcase
	end

	// Store ports and ALU operands for each step.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_addr[AW-1:0];
		mem_wdata = 8'd0;
		fr_we     = 1'b0;
		fr_addr   = 5'(vy_q + 8'(cnt_q[3:0]));
		fr_wdata  = 64'd0;
		gp_we     = 1'b0;
		gp_waddr  = f_x;
		gp_raddr  = cnt_q[3:0];
		gp_wdata  = 8'd0;
		stk_we    = 1'b0;
		stk_raddr = SAW'(sp_q - SPW'(1));
		alu_op    = c8ie_pkg::ALU_PASSB;
		alu_a     = vx_q;
		alu_b     = f_kk;
		case (state_q)
			c8ie_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_addr  = cnt_q;
				mem_wdata = (cnt_q < AW'(c8ie_pkg::FONT_BYTES)) ?
					c8ie_pkg::FONT_ROM[cnt_q[6:0]] : 8'd0;
				fr_we     = (cnt_q < AW'(32));
				fr_addr   = cnt_q[4:0];
				gp_we     = (cnt_q < AW'(16));
				gp_waddr  = cnt_q[3:0];
			end
			c8ie_pkg::ST_MEMW: begin
				mem_we    = addr_ok;
				mem_addr  = addr_q[AW-1:0];
				mem_wdata = data_q;
			end
			c8ie_pkg::ST_MRD:   mem_addr = addr_q[AW-1:0];
			c8ie_pkg::ST_FRD:   fr_addr  = rsel_q;
			c8ie_pkg::ST_FETCH: gp_raddr = f_x;
			c8ie_pkg::ST_RDX:   gp_raddr = f_y;
			c8ie_pkg::ST_RDY:   gp_raddr = 4'd0;
			c8ie_pkg::ST_DECODE: begin
				case (f_hi)
					4'h2: stk_we = (sp_q < SPW'(c8ie_pkg::STACK_DEPTH));
					4'h5, 4'h9: alu_b = vy_q;
					4'h6: begin
						gp_we    = 1'b1;
						gp_wdata = f_kk;
					end
					4'h7: begin
						alu_op   = c8ie_pkg::ALU_ADD;
						gp_we    = 1'b1;
						gp_wdata = alu.res;
					end
					4'h8: begin
						alu_b    = vy_q;
						gp_we    = arith_valid;
						gp_wdata = alu.res;
						case (f_n)
							4'h1: alu_op = c8ie_pkg::ALU_OR;
							4'h2: alu_op = c8ie_pkg::ALU_AND;
							4'h3: alu_op = c8ie_pkg::ALU_XOR;
							4'h4: alu_op = c8ie_pkg::ALU_ADD;
							4'h5: alu_op = c8ie_pkg::ALU_SUB;
							4'h6: alu_op = c8ie_pkg::ALU_SHR;
							4'h7: begin
								alu_op = c8ie_pkg::ALU_SUB;
								alu_a  = vy_q;
								alu_b  = vx_q;
							end
							4'hE: alu_op = c8ie_pkg::ALU_SHL;
							default: alu_op = c8ie_pkg::ALU_PASSB;
						endcase
					end
					4'hC: begin
						gp_we    = 1'b1;
						gp_wdata = rnd_q & f_kk;
					end
					4'hF: begin
						if (f_kk == 8'h07) begin
							gp_we    = 1'b1;
							gp_wdata = delay_q;
						end else if (f_kk == 8'h0A) begin
							gp_we    = keyp_q;
							gp_wdata = {4'd0, keyv_q};
						end
					end
					default: gp_we = 1'b0;
				endcase
			end
			c8ie_pkg::ST_FLAG: begin
				gp_we    = 1'b1;
				gp_waddr = 4'hF;
				gp_wdata = {7'd0, flag_q};
			end
			c8ie_pkg::ST_CLS: begin
				fr_we   = 1'b1;
				fr_addr = cnt_q[4:0];
			end
			c8ie_pkg::ST_DRAW_B: begin
				fr_we    = 1'b1;
				fr_wdata = fr_rd_q ^ sprite_bits;
			end
			c8ie_pkg::ST_DRAW_F: begin
				gp_we    = 1'b1;
				gp_waddr = 4'hF;
				gp_wdata = {7'd0, hit_q};
			end
			c8ie_pkg::ST_BCD_T: begin
				alu_op = c8ie_pkg::ALU_SUB;
				alu_a  = rem_q;
				alu_b  = 8'd10;
			end
			c8ie_pkg::ST_BCD_W: begin
				mem_we = idx_ok;
				case (cnt_q[1:0])
					2'd0:    mem_wdata = {6'd0, hund_q};
					2'd1:    mem_wdata = {4'd0, tens_q};
					default: mem_wdata = rem_q;
				endcase
			end
			c8ie_pkg::ST_STORE_B: begin
				mem_we    = idx_ok;
				mem_wdata = gp_rd_q;
			end
			c8ie_pkg::ST_LOAD_B: begin
				gp_we    = 1'b1;
				gp_waddr = cnt_q[3:0];
				gp_wdata = idx_ok ? mem_rd_q : 8'd0;
			end
			default: gp_we = 1'b0;
		endcase
	end

	// Stores: one write port and one registered read port each.
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_addr] <= mem_wdata;
		mem_rd_q <= mem_q[mem_addr];
		if (fr_we) fr_q[fr_addr] <= fr_wdata;
		fr_rd_q <= fr_q[fr_addr];
		if (gp_we) gp_q[gp_waddr] <= gp_wdata;
		gp_rd_q <= gp_q[gp_raddr];
		if (stk_we) stk_q[sp_q[SAW-1:0]] <= pc_q;
		stk_rd_q <= stk_q[stk_raddr];
	end

	// Captured transfer and working values need no reset.
	always_ff @(posedge clk) begin
		if (state_q == c8ie_pkg::ST_IDLE && start) begin
			opcode_q <= opcode;
			addr_q   <= address;
			data_q   <= data;
			keys_q   <= keys_down;
			keyv_q   <= key_value;
			keyp_q   <= key_present;
			rnd_q    <= random_byte;
			rsel_q   <= row_select;
		end
		if (state_q == c8ie_pkg::ST_RDX) vx_q <= gp_rd_q;
		if (state_q == c8ie_pkg::ST_RDY) vy_q <= gp_rd_q;
		if (state_q == c8ie_pkg::ST_RD0) v0_q <= gp_rd_q;
		if (state_q == c8ie_pkg::ST_DECODE) flag_q <= alu.flag;
		if (state_q == c8ie_pkg::ST_BCD_H) begin
			tens_q <= 4'd0;
			if (vx_q >= 8'd200) begin
				hund_q <= 2'd2;
				rem_q  <= vx_q - 8'd200;
			end else if (vx_q >= 8'd100) begin
				hund_q <= 2'd1;
				rem_q  <= vx_q - 8'd100;
			end else begin
				hund_q <= 2'd0;
				rem_q  <= vx_q;
			end
		end
		if (state_q == c8ie_pkg::ST_BCD_T && alu.ge) begin
			rem_q  <= alu.res;
			tens_q <= tens_q + 4'd1;
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c8ie_pkg::ST_INIT;
			cnt_q   <= '0;
			pc_q    <= c8ie_pkg::PC_START;
			i_q     <= 16'd0;
			vf_q    <= 8'd0;
			delay_q <= 8'd0;
			sound_q <= 8'd0;
			sp_q    <= '0;
			hit_q   <= 1'b0;
			byte_q  <= 8'd0;
			row_q   <= 64'd0;
			wait_q  <= 1'b0;
			fault_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// VF is mirrored so that it can be reported without a read.
			if (gp_we && gp_waddr == 4'hF) vf_q <= gp_wdata;
			case (state_q)
				c8ie_pkg::ST_INIT: cnt_q <= cnt_q + AW'(1);
				c8ie_pkg::ST_IDLE:
					if (start) begin
						byte_q  <= 8'd0;
						row_q   <= 64'd0;
						wait_q  <= 1'b0;
						fault_q <= 1'b0;
						cnt_q   <= '0;
					end
				c8ie_pkg::ST_MEMW: pc_q   <= c8ie_pkg::PC_START;
				c8ie_pkg::ST_MRD2: byte_q <= addr_ok ? mem_rd_q : 8'd0;
				c8ie_pkg::ST_FRD2: row_q  <= fr_rd_q;
				c8ie_pkg::ST_FETCH: pc_q  <= pc_q + 12'd2;
				c8ie_pkg::ST_DECODE: begin
					hit_q <= 1'b0;
					case (f_hi)
						4'h0:
							if (opcode_q == 16'h00EE) begin
								if (sp_q == '0) fault_q <= 1'b1;
								else sp_q <= sp_q - SPW'(1);
							end
						4'h1: pc_q <= f_nnn;
						4'h2:
							if (sp_q < SPW'(c8ie_pkg::STACK_DEPTH)) begin
								sp_q <= sp_q + SPW'(1);
								pc_q <= f_nnn;
							end else begin
								fault_q <= 1'b1;
							end
						4'h3, 4'h5: if (alu.eq) pc_q <= pc_q + 12'd2;
						4'h4, 4'h9: if (!alu.eq) pc_q <= pc_q + 12'd2;
						4'hA: i_q  <= {4'd0, f_nnn};
						4'hB: pc_q <= f_nnn + {4'd0, v0_q};
						4'hE: begin
							if (f_kk == 8'h9E && key_held) pc_q <= pc_q + 12'd2;
							else if (f_kk == 8'hA1 && !key_held) pc_q <= pc_q + 12'd2;
						end
						4'hF: begin
							case (f_kk)
								8'h0A:
									if (!keyp_q) begin
										wait_q <= 1'b1;
										pc_q   <= pc_q - 12'd2;
									end
								8'h15: delay_q <= vx_q;
								8'h18: sound_q <= vx_q;
								8'h1E: i_q <= i_q + {8'd0, vx_q};
								8'h29: i_q <= 16'({vx_q, 2'b00}) + 16'(vx_q);
								default: i_q <= i_q;
							endcase
						end
						default: pc_q <= pc_q;
					endcase
				end
				c8ie_pkg::ST_CLS: cnt_q <= cnt_q + AW'(1);
				c8ie_pkg::ST_RET: pc_q  <= stk_rd_q;
				c8ie_pkg::ST_DRAW_B: begin
					if ((fr_rd_q & sprite_bits) != 64'd0) hit_q <= 1'b1;
					cnt_q <= cnt_q + AW'(1);
				end
				c8ie_pkg::ST_BCD_W:   cnt_q <= cnt_q + AW'(1);
				c8ie_pkg::ST_STORE_B: cnt_q <= cnt_q + AW'(1);
				c8ie_pkg::ST_LOAD_B:  cnt_q <= cnt_q + AW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign busy            = (state_q != c8ie_pkg::ST_IDLE);
	assign done            = (state_q == c8ie_pkg::ST_DONE);
	assign program_counter = pc_q;
	assign index_value     = i_q;
	assign flag_value      = vf_q;
	assign byte_out        = byte_q;
	assign row_pixels      = row_q;
	assign key_wait        = wait_q;
	assign stack_fault     = fault_q;

endmodule
`default_nettype wire
